// ===== rtl/imh_pkg.sv =====
// Shared types and request/status codes for the indexed minimum heap.
package imh_pkg;

    // Request codes.
    localparam logic [2:0] REQ_INSERT   = 3'd0;
    localparam logic [2:0] REQ_PEEK     = 3'd1;
    localparam logic [2:0] REQ_DEL_MIN  = 3'd2;
    localparam logic [2:0] REQ_DEL_HNDL = 3'd3;
    localparam logic [2:0] REQ_CHANGE   = 3'd4;

    // Status codes.
    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_EMPTY = 2'd1;
    localparam logic [1:0] STS_FULL  = 2'd2;
    localparam logic [1:0] STS_BAD   = 2'd3;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] key_value;
        logic [10:0]        handle;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] min_value;
        logic               min_valid;
        logic [10:0]        entry_count;
    } t_rsp;

endpackage

// ===== rtl/imh_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module imh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/indexed_min_heap_top.sv =====
// Top level of the indexed minimum heap: sequencer, heap memory and handle map.
//
// An indexed binary min-heap of signed 32-bit keys. A request is taken when start is high
// and busy is low; exactly one result follows, shown for one cycle with o_done, and it
// cannot be held off. Each inserted key gets the next handle (1, 2, 3 ...), which is never
// reused. Heap slots (key and owning handle) live in one RAM and the handle map (live flag
// and slot) in another, both with registered reads. In the result cycle the next request
// can already be taken. An entry climbs or descends at most log2(CAPACITY) levels: every
// level climbed costs a parent read, every level descended costs up to two child reads from
// the single heap read port. The handle map needs no clearing after reset, since a handle is
// only looked up once it has been issued.
module indexed_min_heap_top #(
    parameter int CAPACITY    = 1024,
    parameter int MAX_HANDLES = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  imh_pkg::t_req i_req,
    output logic          o_done,
    output imh_pkg::t_rsp o_rsp
);

    localparam int SW   = $clog2(CAPACITY + 1);
    localparam int SAW  = $clog2(CAPACITY);
    localparam int HW   = $clog2(MAX_HANDLES + 1);
    localparam int HAW  = $clog2(MAX_HANDLES);
    localparam int CMPW = (HW > 11) ? HW : 11;
    localparam int HDW  = 32 + HW;
    localparam int PDW  = 1 + SW;

    // Sequencer states.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_FIN  = 4'd1;
    localparam logic [3:0] S_DM1  = 4'd2;
    localparam logic [3:0] S_HP   = 4'd3;
    localparam logic [3:0] S_LAST = 4'd4;
    localparam logic [3:0] S_UP   = 4'd5;
    localparam logic [3:0] S_UPC  = 4'd6;
    localparam logic [3:0] S_DN   = 4'd7;
    localparam logic [3:0] S_DL   = 4'd8;
    localparam logic [3:0] S_DR   = 4'd9;
    localparam logic [3:0] S_PUT  = 4'd10;

    logic [3:0]         r_state, n_state;
    logic [SW-1:0]      r_p, n_p;
    logic [SW-1:0]      r_size, n_size;
    logic [HW-1:0]      r_nh, n_nh;
    logic signed [31:0] r_ekey, n_ekey;
    logic [HW-1:0]      r_eown, n_eown;
    logic               r_moved, n_moved;
    logic [SW-1:0]      r_best, n_best;
    logic signed [31:0] r_bkey, n_bkey;
    logic [HW-1:0]      r_bown, n_bown;
    logic [2:0]         r_type, n_type;
    logic [HW-1:0]      r_h, n_h;
    logic [1:0]         r_status, n_status;
    logic signed [31:0] r_min;
    logic               r_done, n_done;

    // Memory ports.
    logic           hw_en, pw_en;
    logic [SAW-1:0] hw_addr, hr_addr;
    logic [HDW-1:0] hw_data, heap_q;
    logic [HAW-1:0] pw_addr, pr_addr;
    logic [PDW-1:0] pw_data, pos_q;

    logic signed [31:0] q_key;
    logic [HW-1:0]      q_own;
    logic [CMPW-1:0]    h_w, nh_w, h_m1;
    logic               h_range_ok;
    logic [SW:0]        lchild, rchild;
    logic [SW-1:0]      p_m1, size_m1, par;
    logic               d_en;
    logic [SW-1:0]      d_slot;
    logic signed [31:0] d_key;
    logic [HW-1:0]      d_own;
    logic [HW-1:0]      d_own_m1, e_own_m1, q_own_m1;

    imh_ram #(.WIDTH(HDW), .DEPTH(CAPACITY)) u_heap_ram (
        .i_clk   (i_clk),
        .i_we    (hw_en),
        .i_waddr (hw_addr),
        .i_wdata (hw_data),
        .i_raddr (hr_addr),
        .o_rdata (heap_q)
    );

    imh_ram #(.WIDTH(PDW), .DEPTH(MAX_HANDLES)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (pw_en),
        .i_waddr (pw_addr),
        .i_wdata (pw_data),
        .i_raddr (pr_addr),
        .o_rdata (pos_q)
    );

    // Field views and address arithmetic.
    assign q_key      = heap_q[HDW-1:HW];
    assign q_own      = heap_q[HW-1:0];
    assign h_w        = CMPW'(i_req.handle);
    assign nh_w       = CMPW'(r_nh);
    assign h_m1       = h_w - 1'b1;
    assign h_range_ok = (h_w != '0) && (h_w <= nh_w);
    assign lchild     = {r_p, 1'b0};
    assign rchild     = lchild + 1'b1;
    assign p_m1       = r_p - 1'b1;
    assign size_m1    = r_size - 1'b1;
    assign par        = r_p >> 1;
    assign d_own_m1   = d_own - 1'b1;
    assign e_own_m1   = r_eown - 1'b1;
    assign q_own_m1   = q_own - 1'b1;
    assign busy       = (r_state != S_IDLE);

    // Sift-down choice: the smallest of the hole's element and the children read so far.
    always_comb begin
        d_en   = 1'b0;
        d_slot = r_p;
        d_key  = r_ekey;
        d_own  = r_eown;
        if (r_state == S_DL) begin
            if (q_key < r_ekey) begin
                d_slot = lchild[SW-1:0];
                d_key  = q_key;
                d_own  = q_own;
            end
            d_en = (rchild > (SW+1)'(r_size));
        end else if (r_state == S_DR) begin
            d_slot = r_best;
            d_key  = r_bkey;
            d_own  = r_bown;
            if (q_key < r_bkey) begin
                d_slot = rchild[SW-1:0];
                d_key  = q_key;
                d_own  = q_own;
            end
            d_en = 1'b1;
        end
    end

    // Request sequencer: read, compare and write back one heap level at a time.
    always_comb begin
        n_state  = r_state;
        n_p      = r_p;
        n_size   = r_size;
        n_nh     = r_nh;
        n_ekey   = r_ekey;
        n_eown   = r_eown;
        n_moved  = r_moved;
        n_best   = r_best;
        n_bkey   = r_bkey;
        n_bown   = r_bown;
        n_type   = r_type;
        n_h      = r_h;
        n_status = r_status;
        n_done   = 1'b0;
        hr_addr  = '0;
        hw_en    = 1'b0;
        hw_addr  = p_m1[SAW-1:0];
        hw_data  = {r_ekey, r_eown};
        pr_addr  = h_m1[HAW-1:0];
        pw_en    = 1'b0;
        pw_addr  = e_own_m1[HAW-1:0];
        pw_data  = {1'b1, r_p};
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_type   = i_req.req_type;
                    n_h      = HW'(i_req.handle);
                    n_ekey   = i_req.key_value;
                    n_status = imh_pkg::STS_OK;
                    n_moved  = 1'b0;
                    n_state  = S_FIN;
                    case (i_req.req_type) inside
                        imh_pkg::REQ_INSERT: begin
                            if (r_size == SW'(CAPACITY) || r_nh == HW'(MAX_HANDLES)) begin
                                n_status = imh_pkg::STS_FULL;
                            end else begin
                                n_nh    = r_nh + 1'b1;
                                n_size  = r_size + 1'b1;
                                n_p     = r_size + 1'b1;
                                n_eown  = r_nh + 1'b1;
                                n_state = S_UP;
                            end
                        end
                        imh_pkg::REQ_PEEK: begin
                            if (r_size == '0) n_status = imh_pkg::STS_EMPTY;
                        end
                        imh_pkg::REQ_DEL_MIN: begin
                            if (r_size == '0) begin
                                n_status = imh_pkg::STS_EMPTY;
                            end else begin
                                hr_addr = '0;
                                n_p     = SW'(1);
                                n_state = S_DM1;
                            end
                        end
                        imh_pkg::REQ_DEL_HNDL, imh_pkg::REQ_CHANGE: begin
                            if (!h_range_ok) n_status = imh_pkg::STS_BAD;
                            else n_state = S_HP;
                        end
                        default: ;
                    endcase
                end
            end
            S_DM1: begin
                // Retire the owner of the root, then fetch the last slot.
                pw_en   = 1'b1;
                pw_addr = q_own_m1[HAW-1:0];
                pw_data = '0;
                hr_addr = size_m1[SAW-1:0];
                n_state = S_LAST;
            end
            S_HP: begin
                if (!pos_q[SW]) begin
                    n_status = imh_pkg::STS_BAD;
                    n_state  = S_FIN;
                end else begin
                    n_p = pos_q[SW-1:0];
                    if (r_type == imh_pkg::REQ_DEL_HNDL) begin
                        pw_en   = 1'b1;
                        pw_addr = HAW'(r_h - 1'b1);
                        pw_data = '0;
                        hr_addr = size_m1[SAW-1:0];
                        n_state = S_LAST;
                    end else begin
                        n_eown  = r_h;
                        n_state = S_UP;
                    end
                end
            end
            S_LAST: begin
                // The last entry fills the hole unless the hole was the last slot.
                n_size = size_m1;
                if (r_p <= size_m1) begin
                    n_ekey  = q_key;
                    n_eown  = q_own;
                    n_state = S_UP;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_UP: begin
                if (r_p == SW'(1)) begin
                    n_state = r_moved ? S_PUT : S_DN;
                end else begin
                    hr_addr = SAW'(par - 1'b1);
                    n_state = S_UPC;
                end
            end
            S_UPC: begin
                if (q_key > r_ekey) begin
                    hw_en   = 1'b1;
                    hw_data = heap_q;
                    pw_en   = 1'b1;
                    pw_addr = q_own_m1[HAW-1:0];
                    n_p     = par;
                    n_moved = 1'b1;
                    n_state = S_UP;
                end else begin
                    n_state = r_moved ? S_PUT : S_DN;
                end
            end
            S_DN: begin
                if (lchild > (SW+1)'(r_size)) begin
                    n_state = S_PUT;
                end else begin
                    hr_addr = SAW'(lchild - 1'b1);
                    n_state = S_DL;
                end
            end
            S_DL, S_DR: begin
                n_best = d_slot;
                n_bkey = d_key;
                n_bown = d_own;
                if (!d_en) begin
                    hr_addr = SAW'(rchild - 1'b1);
                    n_state = S_DR;
                end else if (d_slot == r_p) begin
                    n_state = S_PUT;
                end else begin
                    hw_en   = 1'b1;
                    hw_data = {d_key, d_own};
                    pw_en   = 1'b1;
                    pw_addr = d_own_m1[HAW-1:0];
                    n_p     = d_slot;
                    n_state = S_DN;
                end
            end
            S_PUT: begin
                // Settle the travelling entry in the hole.
                hw_en   = 1'b1;
                pw_en   = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_size  <= '0;
            r_nh    <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_size  <= n_size;
            r_nh    <= n_nh;
            r_done  <= n_done;
        end
    end

    // Working registers and the cached root key.
    always_ff @(posedge i_clk) begin
        r_p      <= n_p;
        r_ekey   <= n_ekey;
        r_eown   <= n_eown;
        r_moved  <= n_moved;
        r_best   <= n_best;
        r_bkey   <= n_bkey;
        r_bown   <= n_bown;
        r_type   <= n_type;
        r_h      <= n_h;
        r_status <= n_status;
        if (hw_en && hw_addr == '0) begin
            r_min <= hw_data[HDW-1:HW];
        end
    end

    // Result transfer.
    assign o_done            = r_done;
    assign o_rsp.status      = r_status;
    assign o_rsp.min_value   = (r_size != '0) ? r_min : 32'sd0;
    assign o_rsp.min_valid   = (r_size != '0);
    assign o_rsp.entry_count = 11'(r_size);

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("sequencer did not leave idle after a request");

    a_size_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_size <= SW'(CAPACITY))
        else $error("entry count above capacity");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while busy");

    a_handles_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nh >= $past(r_nh))
        else $error("handle counter went backwards");

    a_up_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UP) |-> (r_p != '0 && r_p <= r_size))
        else $error("sift position outside the heap");

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the indexed minimum heap: directed and random requests.
module tb_top;

    localparam int CAP   = 1024;
    localparam int HNDLS = 1024;

    // Keeps its own copy of the heap and compares every result with it.
    class heap_scoreboard;
        int            keys [1:CAP];
        int unsigned   owner [1:CAP];
        int unsigned   slot_of [1:HNDLS];
        bit            live [1:HNDLS];
        int unsigned   size;
        int unsigned   issued;
        imh_pkg::t_rsp awaited [$];
        int            errors;

        function void swap_slots(int unsigned a, int unsigned b);
            int          k;
            int unsigned o;
            k = keys[a];
            o = owner[a];
            keys[a] = keys[b];
            owner[a] = owner[b];
            keys[b] = k;
            owner[b] = o;
            slot_of[owner[a]] = a;
            slot_of[owner[b]] = b;
        endfunction

        function void bubble_up(int unsigned p);
            while (p > 1 && keys[p / 2] > keys[p]) begin
                swap_slots(p, p / 2);
                p = p / 2;
            end
        endfunction

        function void bubble_down(int unsigned p);
            int unsigned best;
            forever begin
                best = p;
                if (2 * p <= size && keys[2 * p] < keys[best]) best = 2 * p;
                if (2 * p + 1 <= size && keys[2 * p + 1] < keys[best]) best = 2 * p + 1;
                if (best == p) return;
                swap_slots(best, p);
                p = best;
            end
        endfunction

        // Takes out the entry in slot p; the last slot needs no reordering.
        function void take_slot(int unsigned p);
            live[owner[p]] = 1'b0;
            swap_slots(p, size);
            size--;
            if (p <= size) begin
                bubble_up(p);
                bubble_down(p);
            end
        endfunction

        function bit handle_live(int unsigned h);
            return h != 0 && h <= issued && h <= HNDLS && live[h];
        endfunction

        // Applies one accepted request and queues the result it must produce.
        function void note_request(imh_pkg::t_req r);
            imh_pkg::t_rsp rsp;
            int unsigned   p;
            rsp.status = imh_pkg::STS_OK;
            case (r.req_type)
                imh_pkg::REQ_INSERT: begin
                    if (size >= CAP || issued >= HNDLS) rsp.status = imh_pkg::STS_FULL;
                    else begin
                        issued++;
                        size++;
                        keys[size] = r.key_value;
                        owner[size] = issued;
                        slot_of[issued] = size;
                        live[issued] = 1'b1;
                        bubble_up(size);
                    end
                end
                imh_pkg::REQ_PEEK: begin
                    if (size == 0) rsp.status = imh_pkg::STS_EMPTY;
                end
                imh_pkg::REQ_DEL_MIN: begin
                    if (size == 0) rsp.status = imh_pkg::STS_EMPTY;
                    else take_slot(1);
                end
                imh_pkg::REQ_DEL_HNDL: begin
                    if (!handle_live(r.handle)) rsp.status = imh_pkg::STS_BAD;
                    else take_slot(slot_of[r.handle]);
                end
                imh_pkg::REQ_CHANGE: begin
                    if (!handle_live(r.handle)) rsp.status = imh_pkg::STS_BAD;
                    else begin
                        p = slot_of[r.handle];
                        keys[p] = r.key_value;
                        bubble_up(p);
                        bubble_down(slot_of[r.handle]);
                    end
                end
                default: ;
            endcase
            rsp.min_value   = size != 0 ? keys[1] : 0;
            rsp.min_valid   = size != 0;
            rsp.entry_count = size[10:0];
            awaited.push_back(rsp);
        endfunction

        function void check_result(imh_pkg::t_rsp got);
            imh_pkg::t_rsp want;
            if (awaited.size() == 0) begin
                $error("result with nothing outstanding: %p", got);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.min_value !== want.min_value) begin
                $error("min_value: expected %0d, got %0d", want.min_value, got.min_value);
                errors++;
            end
            if (got.min_valid !== want.min_valid) begin
                $error("min_valid: expected %0d, got %0d", want.min_valid, got.min_valid);
                errors++;
            end
            if (got.entry_count !== want.entry_count) begin
                $error("entry_count: expected %0d, got %0d", want.entry_count,
                       got.entry_count);
                errors++;
            end
        endfunction
    endclass

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           start = 1'b0;
    logic           busy;
    imh_pkg::t_req  i_req = '0;
    logic           o_done;
    imh_pkg::t_rsp  o_rsp;
    heap_scoreboard sb = new();
    bit             gaps_on = 1'b1;

    indexed_min_heap_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Every result is taken the cycle it is shown.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_result(o_rsp);
    end

    // Presents one request and holds it until the transfer; may then idle for a burst.
    task automatic send(imh_pkg::t_req r);
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_request(r);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    task automatic send_fields(logic [2:0] op, int key, int unsigned h);
        imh_pkg::t_req r;
        r.req_type  = op;
        r.key_value = key;
        r.handle    = h[10:0];
        send(r);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    // Random request, mostly aimed at handles that have been issued.
    function automatic imh_pkg::t_req random_request();
        imh_pkg::t_req r;
        int unsigned   pick;
        pick = $urandom_range(0, 99);
        if (pick < 38) r.req_type = imh_pkg::REQ_INSERT;
        else if (pick < 48) r.req_type = imh_pkg::REQ_PEEK;
        else if (pick < 62) r.req_type = imh_pkg::REQ_DEL_MIN;
        else if (pick < 78) r.req_type = imh_pkg::REQ_DEL_HNDL;
        else if (pick < 96) r.req_type = imh_pkg::REQ_CHANGE;
        else r.req_type = 3'($urandom_range(5, 7));
        // Narrow keys give many ties; wide keys reach both signs and extremes.
        if ($urandom_range(0, 2) == 0) r.key_value = $urandom_range(0, 15) - 8;
        else r.key_value = $urandom;
        if ($urandom_range(0, 9) == 0 || sb.issued == 0) r.handle = 11'($urandom);
        else r.handle = 11'($urandom_range(1, sb.issued));
        return r;
    endfunction

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty heap, bad handles, key extremes, last slot, unused codes.
        send_fields(imh_pkg::REQ_PEEK, 0, 0);
        send_fields(imh_pkg::REQ_DEL_MIN, 0, 0);
        send_fields(imh_pkg::REQ_DEL_HNDL, 0, 0);
        send_fields(imh_pkg::REQ_CHANGE, 5, 1);
        send_fields(imh_pkg::REQ_INSERT, 32'h7fffffff, 0);
        send_fields(imh_pkg::REQ_INSERT, 32'h80000000, 0);
        send_fields(imh_pkg::REQ_INSERT, 0, 0);
        send_fields(imh_pkg::REQ_PEEK, 0, 0);
        send_fields(imh_pkg::REQ_CHANGE, 32'h7fffffff, 2);
        send_fields(imh_pkg::REQ_CHANGE, 32'h80000000, 1);
        send_fields(imh_pkg::REQ_DEL_HNDL, 0, 2);
        send_fields(imh_pkg::REQ_DEL_HNDL, 0, 2);
        send_fields(imh_pkg::REQ_CHANGE, 1, 2);
        send_fields(imh_pkg::REQ_INSERT, -1, 0);
        send_fields(imh_pkg::REQ_INSERT, 100, 0);
        send_fields(imh_pkg::REQ_DEL_HNDL, 0, 5);
        send_fields(3'd5, 0, 0);
        send_fields(3'd6, -1, 11'h7ff);
        send_fields(3'd7, 0, 0);
        send_fields(imh_pkg::REQ_DEL_HNDL, 0, 11'h7ff);
        send_fields(imh_pkg::REQ_CHANGE, 0, 11'h400);
        send_fields(imh_pkg::REQ_DEL_MIN, 0, 0);
        send_fields(imh_pkg::REQ_DEL_MIN, 0, 0);
        send_fields(imh_pkg::REQ_DEL_MIN, 0, 0);
        send_fields(imh_pkg::REQ_PEEK, 0, 0);

        // The sender waits here for every outstanding result.
        drain();

        repeat (575) send(random_request());

        // Back-to-back requests to finish.
        gaps_on = 1'b0;
        repeat (150) send(random_request());

        drain();
        if (sb.errors == 0 && sb.awaited.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("status: fail");
        $finish;
    end

endmodule
